// ===== rtl/bma_pkg.sv =====
package bma_pkg;

	localparam int MAX_LOG2   = 10;
	localparam int ADDR_W     = MAX_LOG2;
	localparam int DEPTH      = 1 << MAX_LOG2;
	localparam int OWNER_W    = 16;
	localparam int LOG_W      = 4;
	localparam int SIZE_W     = MAX_LOG2 + 1;
	localparam int CFG_W      = 4;

	typedef struct packed {
		logic               start;
		logic [LOG_W-1:0]   lg;
		logic               used;
		logic [OWNER_W-1:0] owner;
	} entry_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_SCAN_RD,
		S_SCAN_EV,
		S_PICK,
		S_SPLIT,
		S_MRG_CHK,
		S_MRG_RD,
		S_MRG_EV,
		S_FREE_FIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic clr_step;
		logic scan_rd;
		logic scan_ev;
		logic pick;
		logic split_wr;
		logic merge_rd;
		logic merge_ev;
		logic free_fin;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic bad_req;
		logic scan_hit;
		logic scan_end;
		logic alloc_none;
		logic split_more;
		logic merge_more;
		logic merge_ok;
	} sts_t;

endpackage

// ===== rtl/bma_ctrl.sv =====
module bma_ctrl
	import bma_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_ready,
	output logic out_valid,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:    if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:     if (in_valid) state_d = S_START;
			S_START:    if (!sts.is_free && sts.bad_req) state_d = S_DONE;
			            else state_d = S_SCAN_RD;
			S_SCAN_RD:  state_d = S_SCAN_EV;
			S_SCAN_EV: begin
				if (sts.is_free && sts.scan_hit) state_d = S_MRG_CHK;
				else if (sts.scan_end) state_d = sts.is_free ? S_DONE : S_PICK;
				else state_d = S_SCAN_RD;
			end
			S_PICK:     state_d = sts.alloc_none ? S_DONE : S_SPLIT;
			S_SPLIT:    if (!sts.split_more) state_d = S_DONE;
			S_MRG_CHK:  state_d = sts.merge_more ? S_MRG_RD : S_FREE_FIN;
			S_MRG_RD:   state_d = S_MRG_EV;
			S_MRG_EV:   state_d = sts.merge_ok ? S_MRG_CHK : S_FREE_FIN;
			S_FREE_FIN: state_d = S_DONE;
			S_DONE:     if (slot_free) state_d = S_IDLE;
			default:    state_d = S_CLEAR;
		endcase
		if (cfg_we) state_d = S_CLEAR;
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR:    cmd.clr_step = 1'b1;
			S_IDLE:     cmd.accept   = in_valid;
			S_SCAN_RD:  cmd.scan_rd  = 1'b1;
			S_SCAN_EV:  cmd.scan_ev  = 1'b1;
			S_PICK:     cmd.pick     = 1'b1;
			S_SPLIT:    cmd.split_wr = 1'b1;
			S_MRG_RD:   cmd.merge_rd = 1'b1;
			S_MRG_EV:   cmd.merge_ev = 1'b1;
			S_FREE_FIN: cmd.free_fin = 1'b1;
			S_DONE:     cmd.load_out = slot_free;
			default:    cmd = '0;
		endcase
		if (cfg_we) cmd.clr_step = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/bma_dp.sv =====
module bma_dp
	import bma_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               in_op,
	input  logic [OWNER_W-1:0] in_owner,
	input  logic [SIZE_W-1:0]  in_need,
	input  cmd_t               cmd,
	output sts_t               sts,
	output logic [SIZE_W-1:0]  out_grant,
	output logic               out_freed
);

	entry_t mem [DEPTH];

	logic [CFG_W-1:0]   tsl_q;
	logic [SIZE_W-1:0]  clr_q;
	logic               op_q;
	logic [OWNER_W-1:0] owner_q;
	logic [SIZE_W-1:0]  need_q;
	logic [SIZE_W-1:0]  a_q;
	logic [LOG_W-1:0]   best_q;
	logic [ADDR_W-1:0]  pick_q;
	logic [LOG_W-1:0]   cur_q;
	logic [ADDR_W-1:0]  p_q;
	logic [SIZE_W-1:0]  grant_q;
	logic               freed_q;
	logic [SIZE_W-1:0]  out_grant_q;
	logic               out_freed_q;
	entry_t             rd_q;

	logic [LOG_W-1:0]   eff;
	logic [SIZE_W-1:0]  total;
	logic [LOG_W-1:0]   dlog;
	logic [SIZE_W-1:0]  a_next;
	logic [ADDR_W-1:0]  buddy;
	logic [ADDR_W-1:0]  split_right;
	logic               fit;
	logic               we;
	logic [ADDR_W-1:0]  waddr;
	entry_t             wdata;
	logic               re;
	logic [ADDR_W-1:0]  raddr;

	assign eff   = (tsl_q > LOG_W'(MAX_LOG2)) ? LOG_W'(MAX_LOG2) : tsl_q;
	assign total = SIZE_W'(1) << eff;

	// ceiling log2 of the request
	always_comb begin
		dlog = '0;
		for (int d = MAX_LOG2; d >= 0; d--) begin
			if ((SIZE_W'(1) << d) >= need_q) dlog = LOG_W'(d);
		end
	end

	assign a_next      = a_q + (SIZE_W'(1) << rd_q.lg);
	assign buddy       = p_q ^ (ADDR_W'(1) << cur_q);
	assign split_right = pick_q + (ADDR_W'(1) << (cur_q - LOG_W'(1)));
	assign fit         = !rd_q.used && (rd_q.lg >= dlog) && (rd_q.lg < best_q);

	assign sts.clr_last   = (clr_q == SIZE_W'(DEPTH - 1));
	assign sts.is_free    = op_q;
	assign sts.bad_req    = (need_q == '0) || (need_q > total);
	assign sts.scan_hit   = rd_q.used && (rd_q.owner == owner_q);
	assign sts.scan_end   = (a_next >= total);
	assign sts.alloc_none = (best_q > eff);
	assign sts.split_more = (cur_q > dlog);
	assign sts.merge_more = (cur_q < eff);
	assign sts.merge_ok   = rd_q.start && (rd_q.lg == cur_q) && !rd_q.used;

	// one write port, one read port
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		re    = 1'b0;
		raddr = '0;
		if (cmd.clr_step) begin
			we    = 1'b1;
			waddr = clr_q[ADDR_W-1:0];
			if (clr_q == '0) begin
				wdata.start = 1'b1;
				wdata.lg    = eff;
			end
		end
		if (cmd.split_wr) begin
			we = 1'b1;
			if (sts.split_more) begin
				waddr       = split_right;
				wdata.start = 1'b1;
				wdata.lg    = cur_q - LOG_W'(1);
			end else begin
				waddr       = pick_q;
				wdata.start = 1'b1;
				wdata.lg    = dlog;
				wdata.used  = 1'b1;
				wdata.owner = owner_q;
			end
		end
		if (cmd.merge_ev && sts.merge_ok) begin
			we    = 1'b1;
			waddr = (p_q < buddy) ? buddy : p_q;
		end
		if (cmd.free_fin) begin
			we          = 1'b1;
			waddr       = p_q;
			wdata.start = 1'b1;
			wdata.lg    = cur_q;
		end
		if (cmd.scan_rd) begin
			re    = 1'b1;
			raddr = a_q[ADDR_W-1:0];
		end
		if (cmd.merge_rd) begin
			re    = 1'b1;
			raddr = buddy;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsl_q <= CFG_W'(MAX_LOG2);
			clr_q <= '0;
		end else begin
			if (cfg_we) begin
				tsl_q <= cfg_wdata;
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + SIZE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= in_op;
			owner_q <= in_owner;
			need_q  <= in_need;
			a_q     <= '0;
			best_q  <= eff + LOG_W'(1);
			grant_q <= '0;
			freed_q <= 1'b0;
		end
		if (cmd.scan_ev) begin
			a_q <= a_next;
			if (fit) begin
				best_q <= rd_q.lg;
				pick_q <= a_q[ADDR_W-1:0];
			end
			if (sts.scan_hit) begin
				p_q   <= a_q[ADDR_W-1:0];
				cur_q <= rd_q.lg;
			end
		end
		if (cmd.pick) cur_q <= best_q;
		if (cmd.split_wr) begin
			if (sts.split_more) cur_q <= cur_q - LOG_W'(1);
			else grant_q <= SIZE_W'(1) << dlog;
		end
		if (cmd.merge_ev && sts.merge_ok) begin
			p_q   <= (p_q < buddy) ? p_q : buddy;
			cur_q <= cur_q + LOG_W'(1);
		end
		if (cmd.free_fin) freed_q <= 1'b1;
		if (cmd.load_out) begin
			out_grant_q <= grant_q;
			out_freed_q <= freed_q;
		end
	end

	assign out_grant = out_grant_q;
	assign out_freed = out_freed_q;

endmodule

// ===== rtl/buddy_memory_allocator.sv =====
// Buddy allocator over 2^total_size_log2 units (clamped to 1024). Send an allocate
// (tuser 0) with owner id and size; the reply carries the granted power-of-two size,
// or 0 on failure. Send a free (tuser 1) with an owner id; the reply tuser is 1 when
// that owner's lowest block was released, then merged while its buddy is free. One
// request is worked at a time: the block table is a 1024-entry single-write,
// single-read memory, and each request walks it block by block, then splits or
// merges level by level. The reply sits in an output register, so the next request
// is taken while it waits. After reset and after every write of total_size_log2 the
// table is cleared entry by entry, during which no request is accepted; a write
// discards all allocations.
module buddy_memory_allocator
	import bma_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,      // total_size_log2
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] process_id, [26:16] request_size
	input  logic        s_axis_tuser,   // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [10:0] granted_size
	output logic        m_axis_tuser    // freed
);

	cmd_t              cmd;
	sts_t              sts;
	logic [SIZE_W-1:0] grant;

	bma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.sts       (sts),
		.cmd       (cmd)
	);

	bma_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_op     (s_axis_tuser),
		.in_owner  (s_axis_tdata[15:0]),
		.in_need   (s_axis_tdata[26:16]),
		.cmd       (cmd),
		.sts       (sts),
		.out_grant (grant),
		.out_freed (m_axis_tuser)
	);

	// pad the granted size out to a whole word
	assign m_axis_tdata = {5'd0, grant};

endmodule
